@@ rtl/assert_macros.svh @@
// Assertion macros shared by the resource pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPWQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rpwq_pkg.sv @@
// Package with shared widths, codes and interface structs of the resource pool.
`timescale 1ns / 1ps
package rpwq_pkg;

    localparam int RES_W     = 7;
    localparam int TAG_W     = 16;
    localparam int STAMP_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int RES_LIMIT = 127;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    localparam int S_TAG_LSB   = 0;
    localparam int S_WAIT_BIT  = 16;
    localparam int S_NUM_LSB   = 17;
    localparam int S_STAMP_LSB = 24;

    localparam int DEF_MAX_RESOURCES = 64;
    localparam int DEF_WAIT_DEPTH    = 64;
    localparam int RESET_POOL_SIZE   = 64;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_DECLINED  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_WAIT_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic load_item;
        logic hold_rd;
        logic free_rd;
        logic wait_rd;
        logic do_grant;
        logic grant_from_wait;
        logic do_nogrant;
        logic do_release;
    } ctrl_cmd_t;

    typedef struct packed {
        logic free_avail;
        logic serve_next;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/rpwq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rpwq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rpwq_ctrl.sv @@
// Controller state machine that sequences requests, releases and waiter service.
`timescale 1ns / 1ps
module rpwq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  item_cmd,
    input  rpwq_pkg::dp_status_t  status,
    output rpwq_pkg::ctrl_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_GRANT       = 3'd1;
    localparam logic [2:0] ST_NOGRANT     = 3'd2;
    localparam logic [2:0] ST_RELEASE     = 3'd3;
    localparam logic [2:0] ST_SERVE       = 3'd4;
    localparam logic [2:0] ST_SERVE_GRANT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load_item = 1'b1;
                    if (item_cmd == rpwq_pkg::CMD_RELEASE) begin
                        cmd.hold_rd = 1'b1;
                        state_next  = ST_RELEASE;
                    end else if (status.free_avail) begin
                        cmd.free_rd = 1'b1;
                        state_next  = ST_GRANT;
                    end else begin
                        state_next = ST_NOGRANT;
                    end
                end
            end
            ST_GRANT, ST_SERVE_GRANT: begin
                if (status.out_free) begin
                    cmd.do_grant        = 1'b1;
                    cmd.grant_from_wait = (state_reg == ST_SERVE_GRANT);
                    state_next          = ST_IDLE;
                end
            end
            ST_NOGRANT: begin
                if (status.out_free) begin
                    cmd.do_nogrant = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RELEASE: begin
                if (status.out_free) begin
                    cmd.do_release = 1'b1;
                    state_next     = status.serve_next ? ST_SERVE : ST_IDLE;
                end
            end
            ST_SERVE: begin
                cmd.free_rd = 1'b1;
                cmd.wait_rd = 1'b1;
                state_next  = ST_SERVE_GRANT;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/rpwq_datapath.sv @@
// Datapath with the free list, holder table, wait queue and result register.
`timescale 1ns / 1ps
module rpwq_datapath #(
    parameter int MAX_RESOURCES = rpwq_pkg::DEF_MAX_RESOURCES,
    parameter int WAIT_DEPTH    = rpwq_pkg::DEF_WAIT_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rpwq_pkg::RES_W-1:0]        cfg_wr_data,
    input  logic [rpwq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  rpwq_pkg::ctrl_cmd_t               cmd,
    output rpwq_pkg::dp_status_t              status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rpwq_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [rpwq_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tlast
);

    localparam int RES_W      = rpwq_pkg::RES_W;
    localparam int TAG_W      = rpwq_pkg::TAG_W;
    localparam int STAMP_W    = rpwq_pkg::STAMP_W;
    localparam int HOLD_DEPTH = (MAX_RESOURCES < rpwq_pkg::RES_LIMIT) ?
                                MAX_RESOURCES : rpwq_pkg::RES_LIMIT;
    localparam int HIDX_W     = $clog2(HOLD_DEPTH);
    localparam int FIDX_W     = $clog2(MAX_RESOURCES);
    localparam int WIDX_W     = $clog2(WAIT_DEPTH);
    localparam int WCNT_W     = $clog2(WAIT_DEPTH + 1);
    localparam int RST_POOL   = (MAX_RESOURCES < rpwq_pkg::RESET_POOL_SIZE) ?
                                MAX_RESOURCES : rpwq_pkg::RESET_POOL_SIZE;
    localparam int RST_TAIL   = (RST_POOL == MAX_RESOURCES) ? 0 : RST_POOL;

    // Latched input item.
    logic [TAG_W-1:0]   tag_reg;
    logic               wait_reg;
    logic [RES_W-1:0]   num_reg;
    logic [STAMP_W-1:0] stamp_reg;

    // Pool bookkeeping.
    logic [RES_W-1:0]      free_count_reg;
    logic [FIDX_W-1:0]     free_head_reg;
    logic [FIDX_W-1:0]     free_tail_reg;
    logic [RES_W-1:0]      init_left_reg;
    logic [HOLD_DEPTH-1:0] holder_valid_reg;
    logic [WIDX_W-1:0]     wait_head_reg;
    logic [WIDX_W-1:0]     wait_tail_reg;
    logic [WCNT_W-1:0]     wait_count_reg;

    // Result register.
    logic                                out_valid_reg;
    logic [rpwq_pkg::STATUS_W-1:0]       out_status_reg;
    logic [RES_W-1:0]                    out_res_reg;
    logic [TAG_W-1:0]                    out_tag_reg;
    logic [STAMP_W-1:0]                  out_stamp_reg;
    logic                                out_last_reg;

    logic [RES_W-1:0]         s_num;
    logic [HIDX_W-1:0]        s_hidx;
    logic [HIDX_W-1:0]        rel_hidx;
    logic                     rel_in_range;
    logic                     found;
    logic                     wait_full;
    logic [RES_W-1:0]         pool_n;
    logic [FIDX_W-1:0]        tail_n;
    logic [RES_W-1:0]         grant_res;
    logic [HIDX_W-1:0]        grant_hidx;
    logic [TAG_W-1:0]         grant_tag;
    logic [FIDX_W-1:0]        free_head_inc;
    logic [FIDX_W-1:0]        free_tail_inc;
    logic [WIDX_W-1:0]        wait_head_inc;
    logic [WIDX_W-1:0]        wait_tail_inc;
    logic                     queue_push;
    logic                     free_push;

    logic [RES_W-1:0]         free_rd_data;
    logic [TAG_W-1:0]         wait_rd_data;
    logic [TAG_W+STAMP_W-1:0] hold_rd_data;

    assign s_num  = s_tdata[rpwq_pkg::S_NUM_LSB +: RES_W];
    assign s_hidx = HIDX_W'(s_num - RES_W'(1));

    assign rel_hidx     = HIDX_W'(num_reg - RES_W'(1));
    assign rel_in_range = (num_reg != '0) && (num_reg <= RES_W'(HOLD_DEPTH));
    assign found        = rel_in_range && holder_valid_reg[rel_hidx];
    assign wait_full    = (wait_count_reg == WCNT_W'(WAIT_DEPTH));

    assign status.free_avail = (free_count_reg != '0);
    assign status.serve_next = ((free_count_reg != '0) || found) && (wait_count_reg != '0);
    assign status.out_free   = !out_valid_reg || m_tready;

    // Entries of the initial load are implied by their position until first consumed.
    assign grant_res  = (init_left_reg != '0) ? (RES_W'(free_head_reg) + RES_W'(1))
                                              : free_rd_data;
    assign grant_hidx = HIDX_W'(grant_res - RES_W'(1));
    assign grant_tag  = cmd.grant_from_wait ? wait_rd_data : tag_reg;

    assign free_head_inc = (free_head_reg == FIDX_W'(MAX_RESOURCES - 1)) ? '0
                         : free_head_reg + FIDX_W'(1);
    assign free_tail_inc = (free_tail_reg == FIDX_W'(MAX_RESOURCES - 1)) ? '0
                         : free_tail_reg + FIDX_W'(1);
    assign wait_head_inc = (wait_head_reg == WIDX_W'(WAIT_DEPTH - 1)) ? '0
                         : wait_head_reg + WIDX_W'(1);
    assign wait_tail_inc = (wait_tail_reg == WIDX_W'(WAIT_DEPTH - 1)) ? '0
                         : wait_tail_reg + WIDX_W'(1);

    assign queue_push = cmd.do_nogrant && wait_reg && !wait_full;
    assign free_push  = cmd.do_release && found;

    always_comb begin
        if (cfg_wr_data == '0) begin
            pool_n = RES_W'(1);
        end else if (int'(cfg_wr_data) > MAX_RESOURCES) begin
            pool_n = RES_W'(HOLD_DEPTH);
        end else begin
            pool_n = cfg_wr_data;
        end
        tail_n = (int'(pool_n) == MAX_RESOURCES) ? '0 : FIDX_W'(pool_n);
    end

    rpwq_ram #(
        .WIDTH (RES_W),
        .DEPTH (MAX_RESOURCES)
    ) u_free_ram (
        .aclk    (aclk),
        .wr_en   (free_push),
        .wr_addr (free_tail_reg),
        .wr_data (num_reg),
        .rd_en   (cmd.free_rd),
        .rd_addr (free_head_reg),
        .rd_data (free_rd_data)
    );

    rpwq_ram #(
        .WIDTH (TAG_W + STAMP_W),
        .DEPTH (HOLD_DEPTH)
    ) u_hold_ram (
        .aclk    (aclk),
        .wr_en   (cmd.do_grant),
        .wr_addr (grant_hidx),
        .wr_data ({grant_tag, stamp_reg}),
        .rd_en   (cmd.hold_rd),
        .rd_addr (s_hidx),
        .rd_data (hold_rd_data)
    );

    rpwq_ram #(
        .WIDTH (TAG_W),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .aclk    (aclk),
        .wr_en   (queue_push),
        .wr_addr (wait_tail_reg),
        .wr_data (tag_reg),
        .rd_en   (cmd.wait_rd),
        .rd_addr (wait_head_reg),
        .rd_data (wait_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            tag_reg   <= s_tdata[rpwq_pkg::S_TAG_LSB +: TAG_W];
            wait_reg  <= s_tdata[rpwq_pkg::S_WAIT_BIT];
            num_reg   <= s_num;
            stamp_reg <= s_tdata[rpwq_pkg::S_STAMP_LSB +: STAMP_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_count_reg   <= RES_W'(RST_POOL);
            free_head_reg    <= '0;
            free_tail_reg    <= FIDX_W'(RST_TAIL);
            init_left_reg    <= RES_W'(RST_POOL);
            holder_valid_reg <= '0;
            wait_head_reg    <= '0;
            wait_tail_reg    <= '0;
            wait_count_reg   <= '0;
        end else if (cfg_wr_en) begin
            free_count_reg   <= pool_n;
            free_head_reg    <= '0;
            free_tail_reg    <= tail_n;
            init_left_reg    <= pool_n;
            holder_valid_reg <= '0;
            wait_head_reg    <= '0;
            wait_tail_reg    <= '0;
            wait_count_reg   <= '0;
        end else begin
            if (cmd.do_grant) begin
                holder_valid_reg[grant_hidx] <= 1'b1;
                free_head_reg                <= free_head_inc;
                free_count_reg               <= free_count_reg - RES_W'(1);
                if (init_left_reg != '0) begin
                    init_left_reg <= init_left_reg - RES_W'(1);
                end
            end
            if (free_push) begin
                holder_valid_reg[rel_hidx] <= 1'b0;
                free_tail_reg              <= free_tail_inc;
                free_count_reg             <= free_count_reg + RES_W'(1);
            end
            if (queue_push) begin
                wait_tail_reg  <= wait_tail_inc;
                wait_count_reg <= wait_count_reg + WCNT_W'(1);
            end
            if (cmd.wait_rd) begin
                wait_head_reg  <= wait_head_inc;
                wait_count_reg <= wait_count_reg - WCNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.do_grant || cmd.do_nogrant || cmd.do_release) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.do_grant) begin
            out_status_reg <= rpwq_pkg::STATUS_GRANTED;
            out_res_reg    <= grant_res;
            out_tag_reg    <= grant_tag;
            out_stamp_reg  <= stamp_reg;
            out_last_reg   <= 1'b1;
        end else if (cmd.do_nogrant) begin
            if (!wait_reg) begin
                out_status_reg <= rpwq_pkg::STATUS_DECLINED;
            end else if (wait_full) begin
                out_status_reg <= rpwq_pkg::STATUS_WAIT_FULL;
            end else begin
                out_status_reg <= rpwq_pkg::STATUS_QUEUED;
            end
            out_res_reg   <= '0;
            out_tag_reg   <= tag_reg;
            out_stamp_reg <= '0;
            out_last_reg  <= 1'b1;
        end else if (cmd.do_release) begin
            if (found) begin
                out_status_reg <= rpwq_pkg::STATUS_RELEASED;
                out_res_reg    <= num_reg;
                out_tag_reg    <= hold_rd_data[STAMP_W +: TAG_W];
                out_stamp_reg  <= hold_rd_data[STAMP_W-1:0];
            end else begin
                out_status_reg <= rpwq_pkg::STATUS_NOT_FOUND;
                out_res_reg    <= '0;
                out_tag_reg    <= '0;
                out_stamp_reg  <= '0;
            end
            out_last_reg <= !status.serve_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(rpwq_pkg::M_TDATA_W - RES_W - TAG_W - STAMP_W){1'b0}},
                       out_stamp_reg, out_tag_reg, out_res_reg};

endmodule

@@ rtl/resource_pool_with_wait_queue.sv @@
// Top level of the resource pool with FIFO free list and FIFO wait queue.
//
// Requests and releases arrive as transfers on the s_ channel; s_tuser selects
// request or release. Each request gives one result transfer on the m_ channel;
// a release gives one or two, the second being a grant to the oldest waiter.
// m_tlast marks the final result of an item and m_tuser carries its status.
// A request passes the grant or no-grant state, a release the release state,
// plus serve and serve-grant when it serves a waiter; one item is in work at a
// time, and each RAM lookup is a registered read before its result is formed.
// A finished result sits in an output register, so the next item is accepted
// while that result waits; when the receiver stalls, the block holds the
// result and stops once the next result is ready.
// Reset (aresetn low, synchronous) loads a pool of 64 resources, capped by
// MAX_RESOURCES, and empties the holder table and the wait queue at once.
// A write on cfg_wr_en while idle sets the pool size and reloads the same way.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module resource_pool_with_wait_queue #(
    parameter int MAX_RESOURCES = rpwq_pkg::DEF_MAX_RESOURCES,
    parameter int WAIT_DEPTH    = rpwq_pkg::DEF_WAIT_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rpwq_pkg::RES_W-1:0]     cfg_wr_data,  // pool_size
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // requester_tag[15:0], wait_if_busy[16], release_number[23:17],
    // time_stamp[39:24]
    input  logic [rpwq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rpwq_pkg::S_TUSER_W-1:0] s_tuser,      // cmd[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // resource_number[6:0], holder_tag[22:7], start_stamp[38:23], zero[39]
    output logic [rpwq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [rpwq_pkg::M_TUSER_W-1:0] m_tuser,      // status[2:0]
    output logic                           m_tlast
);

    rpwq_pkg::ctrl_cmd_t  ctrl_cmd;
    rpwq_pkg::dp_status_t dp_status;

    rpwq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .item_cmd (s_tuser[0]),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    rpwq_datapath #(
        .MAX_RESOURCES (MAX_RESOURCES),
        .WAIT_DEPTH    (WAIT_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (ctrl_cmd),
        .status      (dp_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    `RPWQ_ASSERT_NEXT(a_one_item_at_a_time, aclk, aresetn,
        s_tvalid && s_tready, !s_tready, "input accepted while an item is in work")

    `RPWQ_ASSERT_SAME(a_first_of_two_is_release, aclk, aresetn,
        m_tvalid && !m_tlast,
        m_tuser == rpwq_pkg::STATUS_RELEASED || m_tuser == rpwq_pkg::STATUS_NOT_FOUND,
        "non-final result is not a release result")

    `RPWQ_ASSERT_SAME(a_grant_has_resource, aclk, aresetn,
        m_tvalid && m_tuser == rpwq_pkg::STATUS_GRANTED,
        m_tdata[rpwq_pkg::RES_W-1:0] != '0, "grant without a resource number")

    `RPWQ_ASSERT_SAME(a_refusal_has_no_resource, aclk, aresetn,
        m_tvalid && (m_tuser == rpwq_pkg::STATUS_QUEUED ||
                     m_tuser == rpwq_pkg::STATUS_DECLINED ||
                     m_tuser == rpwq_pkg::STATUS_WAIT_FULL),
        m_tdata[rpwq_pkg::RES_W-1:0] == '0, "refused request carries a resource number")

endmodule
